// ===== rtl/core/tfb_pkg.sv =====
// Package with shared types and constants of the text framebuffer blitter.
package tfb_pkg;

	localparam int DEF_MAX_COLUMNS = 128;
	localparam int DEF_MAX_ROWS    = 64;

	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 16;

	localparam logic [7:0] BLANK_CHAR = 8'h20;

	localparam logic [7:0] RST_SCREEN_WIDTH  = 8'd80;
	localparam logic [6:0] RST_SCREEN_HEIGHT = 7'd25;
	localparam logic [7:0] RST_TB_BORDER     = 8'd45;
	localparam logic [7:0] RST_SIDE_BORDER   = 8'd124;

	typedef enum logic [2:0] {
		MODE_BLIT    = 3'd0,
		MODE_OUTLINE = 3'd1,
		MODE_FILL    = 3'd2,
		MODE_CLEAR   = 3'd3,
		MODE_READ    = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		CFG_SCREEN_WIDTH  = 2'd0,
		CFG_SCREEN_HEIGHT = 2'd1,
		CFG_TB_BORDER     = 2'd2,
		CFG_SIDE_BORDER   = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SWEEP,
		ST_READ,
		ST_HOLD
	} eng_state_t;

	// Effective screen geometry and border characters.
	typedef struct packed {
		logic [7:0] width;
		logic [6:0] height;
		logic [7:0] tb_border;
		logic [7:0] side_border;
	} cfg_t;

	typedef struct packed {
		logic [7:0] transparent_char;
		logic [7:0] glyph;
		logic [6:0] size_y;
		logic [7:0] size_x;
		logic [7:0] pos_y;
		logic [8:0] pos_x;
		logic [2:0] mode;
	} cmd_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] read_char;
		logic       status;
	} res_t;

endpackage

// ===== rtl/core/text_framebuffer_blitter.sv =====
// Top level of the text framebuffer blitter: configuration, engine, store, result stage.
//
//  Channel  Direction  Signals                          Contents
//  s_*      in         s_tvalid s_tready s_tdata[55:0]  drawing command
//  m_*      out        m_tvalid m_tready m_tdata[15:0]  one result per command
//  cfg_*    in         cfg_valid cfg_ready cfg_index    register write
//                      cfg_data[7:0]
//
// Sequencing: a blit, a border read, an invalid mode or an empty rectangle finishes
// in the cycle it is taken; a read of a stored cell waits for the registered read
// port of the cell store. Outline, fill and clear sweep the clipped area, and the
// sequencer writes one cell per cycle.
// After reset every cell of the store is swept to spaces; s_tready stays low
// meanwhile, configuration is taken.
// A finished result waits in the output register; the engine keeps a second
// result in its own slot while that register is still occupied.
module text_framebuffer_blitter #(
	parameter int MAX_COLUMNS = tfb_pkg::DEF_MAX_COLUMNS,
	parameter int MAX_ROWS    = tfb_pkg::DEF_MAX_ROWS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// Fields from bit 0 up: mode[2:0], pos_x[11:3], pos_y[19:12], size_x[27:20],
	// size_y[34:28], glyph[42:35], transparent_char[50:43], zero fill [55:51].
	input  logic [tfb_pkg::IN_TDATA_W-1:0]  s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// Fields from bit 0 up: read_char[7:0], status[8], zero fill [15:9].
	output logic [tfb_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [1:0]                     cfg_index,
	input  logic [7:0]                     cfg_data
);

	localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int ADDR_W = COL_W + ROW_W;

	logic [7:0] width_q;
	logic [6:0] height_q;
	logic [7:0] tb_border_q;
	logic [7:0] side_border_q;

	tfb_pkg::cfg_t cfg;
	tfb_pkg::cmd_t cmd;
	tfb_pkg::res_t res;

	logic              out_valid_q;
	logic [7:0]        out_rc_q;
	logic              out_st_q;
	logic              out_free;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [7:0]        mem_wdata;
	logic [ADDR_W-1:0] mem_raddr;
	logic [7:0]        mem_rdata;

	// Configuration writes are always taken; the sender must issue them only while no
	// command is in flight, which the block itself does not enforce.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q       <= tfb_pkg::RST_SCREEN_WIDTH;
			height_q      <= tfb_pkg::RST_SCREEN_HEIGHT;
			tb_border_q   <= tfb_pkg::RST_TB_BORDER;
			side_border_q <= tfb_pkg::RST_SIDE_BORDER;
		end else if (cfg_valid && cfg_ready) begin
			unique case (tfb_pkg::cfg_reg_t'(cfg_index))
				tfb_pkg::CFG_SCREEN_WIDTH:  width_q       <= cfg_data;
				tfb_pkg::CFG_SCREEN_HEIGHT: height_q      <= cfg_data[6:0];
				tfb_pkg::CFG_TB_BORDER:     tb_border_q   <= cfg_data;
				tfb_pkg::CFG_SIDE_BORDER:   side_border_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A screen larger than the store is limited to the store's size.
	always_comb begin
		cfg.width       = ({1'b0, width_q} > 9'(MAX_COLUMNS)) ? 8'(MAX_COLUMNS) : width_q;
		cfg.height      = ({1'b0, height_q} > 8'(MAX_ROWS)) ? 7'(MAX_ROWS) : height_q;
		cfg.tb_border   = tb_border_q;
		cfg.side_border = side_border_q;
	end

	assign cmd.mode             = s_tdata[2:0];
	assign cmd.pos_x            = s_tdata[11:3];
	assign cmd.pos_y            = s_tdata[19:12];
	assign cmd.size_x           = s_tdata[27:20];
	assign cmd.size_y           = s_tdata[34:28];
	assign cmd.glyph            = s_tdata[42:35];
	assign cmd.transparent_char = s_tdata[50:43];

	tfb_engine #(
		.COL_W (COL_W),
		.ROW_W (ROW_W)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.cmd       (cmd),
		.out_free  (out_free),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	tfb_cell_mem #(
		.ADDR_W (ADDR_W)
	) u_cell_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Output register: it can take a new result in the cycle its transaction completes.
	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			out_rc_q <= res.read_char;
			out_st_q <= res.status;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_st_q, out_rc_q};

endmodule

// ===== rtl/core/tfb_cell_mem.sv =====
// Character cell store: one write port and one registered read port.
module tfb_cell_mem #(
	parameter int ADDR_W = 13
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [7:0]        wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [7:0]        rdata
);

	localparam int DEPTH = 1 << ADDR_W;

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/tfb_engine.sv =====
// Drawing sequencer: decodes commands, sweeps rectangles and clears the store.
module tfb_engine #(
	parameter int COL_W = 7,
	parameter int ROW_W = 6
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  tfb_pkg::cfg_t            cfg,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  tfb_pkg::cmd_t            cmd,
	input  logic                     out_free,
	output tfb_pkg::res_t            res,
	output logic                     mem_we,
	output logic [COL_W+ROW_W-1:0]   mem_waddr,
	output logic [7:0]               mem_wdata,
	output logic [COL_W+ROW_W-1:0]   mem_raddr,
	input  logic [7:0]               mem_rdata
);

	localparam int ADDR_W = COL_W + ROW_W;

	tfb_pkg::eng_state_t state_q, state_d;
	logic [ADDR_W-1:0]   clr_q;

	logic [7:0]        x_q, x0_q, x1_q;
	logic [6:0]        y_q, y1_q;
	logic [7:0]        glyph_q;
	logic              outline_q;
	logic signed [10:0] left_q, right_q;
	logic signed [9:0]  top_q, bot_q;
	logic [7:0]        hold_rc_q;
	logic              hold_st_q;

	// Rectangle bounds from the incoming command.
	logic signed [10:0] px_ext, x_end, w_ext, x1_clip, x0_ext;
	logic signed [9:0]  py_ext, y_end, h_ext, y1_clip, y0_ext;
	logic               box_empty;
	logic               is_clear;
	logic [7:0]         ld_x0, ld_x1;
	logic [6:0]         ld_y0, ld_y1;

	// Frame read decode.
	logic [8:0] w_p1;
	logic [7:0] h_p1;
	logic       frame_out, on_tb, on_side, blit_vis;
	logic [7:0] px_m1;
	logic [6:0] py_m1;

	logic       on_edge, last_x, last_y;
	logic       fin, fin_st, load_sweep;
	logic [7:0] fin_rc;

	assign is_clear = (tfb_pkg::mode_t'(cmd.mode) == tfb_pkg::MODE_CLEAR);

	always_comb begin
		px_ext  = $signed({{2{cmd.pos_x[8]}}, cmd.pos_x});
		x_end   = px_ext + $signed({3'b000, cmd.size_x});
		w_ext   = $signed({3'b000, cfg.width});
		x1_clip = (x_end > w_ext) ? w_ext : x_end;
		x0_ext  = cmd.pos_x[8] ? 11'sd0 : $signed({3'b000, cmd.pos_x[7:0]});

		py_ext  = $signed({{2{cmd.pos_y[7]}}, cmd.pos_y});
		y_end   = py_ext + $signed({3'b000, cmd.size_y});
		h_ext   = $signed({3'b000, cfg.height});
		y1_clip = (y_end > h_ext) ? h_ext : y_end;
		y0_ext  = cmd.pos_y[7] ? 10'sd0 : $signed({3'b000, cmd.pos_y[6:0]});

		if (is_clear) begin
			box_empty = (cfg.width == 8'd0) || (cfg.height == 7'd0);
			ld_x0     = 8'd0;
			ld_x1     = cfg.width;
			ld_y0     = 7'd0;
			ld_y1     = cfg.height;
		end else begin
			box_empty = (x1_clip <= x0_ext) || (y1_clip <= y0_ext);
			ld_x0     = x0_ext[7:0];
			ld_x1     = x1_clip[7:0];
			ld_y0     = y0_ext[6:0];
			ld_y1     = y1_clip[6:0];
		end
	end

	always_comb begin
		w_p1      = {1'b0, cfg.width} + 9'd1;
		h_p1      = {1'b0, cfg.height} + 8'd1;
		frame_out = cmd.pos_x[8] || cmd.pos_y[7] || (cmd.pos_x > w_p1) || (cmd.pos_y > h_p1);
		on_tb     = (cmd.pos_y == 8'd0) || (cmd.pos_y == h_p1);
		on_side   = (cmd.pos_x == 9'd0) || (cmd.pos_x == w_p1);
		px_m1     = cmd.pos_x[7:0] - 8'd1;
		py_m1     = cmd.pos_y[6:0] - 7'd1;
		blit_vis  = !cmd.pos_x[8] && !cmd.pos_y[7] && (cmd.pos_x[7:0] < cfg.width)
			&& (cmd.pos_y[6:0] < cfg.height);
	end

	assign mem_raddr = {py_m1[ROW_W-1:0], px_m1[COL_W-1:0]};

	assign on_edge = ($signed({3'b000, x_q}) == left_q) || ($signed({3'b000, x_q}) == right_q)
		|| ($signed({3'b000, y_q}) == top_q) || ($signed({3'b000, y_q}) == bot_q);
	assign last_x  = ((x_q + 8'd1) == x1_q);
	assign last_y  = ((y_q + 7'd1) == y1_q);

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		mem_we     = 1'b0;
		mem_waddr  = {y_q[ROW_W-1:0], x_q[COL_W-1:0]};
		mem_wdata  = glyph_q;
		fin        = 1'b0;
		fin_rc     = 8'd0;
		fin_st     = 1'b0;
		load_sweep = 1'b0;
		res        = '0;

		unique case (state_q)
			tfb_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = tfb_pkg::BLANK_CHAR;
				if (&clr_q) begin
					state_d = tfb_pkg::ST_IDLE;
				end
			end
			tfb_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (tfb_pkg::mode_t'(cmd.mode))
						tfb_pkg::MODE_BLIT: begin
							mem_we    = blit_vis && (cmd.glyph != cmd.transparent_char);
							mem_waddr = {cmd.pos_y[ROW_W-1:0], cmd.pos_x[COL_W-1:0]};
							mem_wdata = cmd.glyph;
							fin       = 1'b1;
							fin_st    = !blit_vis;
						end
						tfb_pkg::MODE_OUTLINE, tfb_pkg::MODE_FILL, tfb_pkg::MODE_CLEAR: begin
							if (box_empty) begin
								fin    = 1'b1;
								fin_st = !is_clear;
							end else begin
								load_sweep = 1'b1;
								state_d    = tfb_pkg::ST_SWEEP;
							end
						end
						tfb_pkg::MODE_READ: begin
							if (frame_out) begin
								fin    = 1'b1;
								fin_st = 1'b1;
							end else if (on_tb) begin
								fin    = 1'b1;
								fin_rc = cfg.tb_border;
							end else if (on_side) begin
								fin    = 1'b1;
								fin_rc = cfg.side_border;
							end else begin
								state_d = tfb_pkg::ST_READ;
							end
						end
						default: begin
							fin    = 1'b1;
							fin_st = 1'b1;
						end
					endcase
				end
			end
			tfb_pkg::ST_SWEEP: begin
				mem_we = !outline_q || on_edge;
				if (last_x && last_y) begin
					fin = 1'b1;
				end
			end
			tfb_pkg::ST_READ: begin
				fin    = 1'b1;
				fin_rc = mem_rdata;
			end
			tfb_pkg::ST_HOLD: begin
				if (out_free) begin
					res.valid     = 1'b1;
					res.read_char = hold_rc_q;
					res.status    = hold_st_q;
					state_d       = tfb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tfb_pkg::ST_IDLE;
			end
		endcase

		// A finished result goes straight to the output stage when it has room.
		if (fin) begin
			if (out_free) begin
				res.valid     = 1'b1;
				res.read_char = fin_rc;
				res.status    = fin_st;
				state_d       = tfb_pkg::ST_IDLE;
			end else begin
				state_d = tfb_pkg::ST_HOLD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tfb_pkg::ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == tfb_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin && !out_free) begin
			hold_rc_q <= fin_rc;
			hold_st_q <= fin_st;
		end
		if (load_sweep) begin
			x_q       <= ld_x0;
			x0_q      <= ld_x0;
			x1_q      <= ld_x1;
			y_q       <= ld_y0;
			y1_q      <= ld_y1;
			glyph_q   <= is_clear ? tfb_pkg::BLANK_CHAR : cmd.glyph;
			outline_q <= (tfb_pkg::mode_t'(cmd.mode) == tfb_pkg::MODE_OUTLINE);
			left_q    <= px_ext;
			right_q   <= x_end - 11'sd1;
			top_q     <= py_ext;
			bot_q     <= y_end - 10'sd1;
		end else if (state_q == tfb_pkg::ST_SWEEP) begin
			if (last_x) begin
				x_q <= x0_q;
				y_q <= y_q + 7'd1;
			end else begin
				x_q <= x_q + 8'd1;
			end
		end
	end

endmodule

// ===== rtl/core/tfb_checker.sv =====
// Port-level checker for the text framebuffer blitter, bound to the top level.
module tfb_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [tfb_pkg::IN_TDATA_W-1:0]  s_tdata,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [tfb_pkg::OUT_TDATA_W-1:0] m_tdata
);

	logic in_acc, blit_acc, bad_acc;

	assign in_acc   = s_tvalid && s_tready;
	assign blit_acc = in_acc && (s_tdata[2:0] == tfb_pkg::MODE_BLIT);
	assign bad_acc  = in_acc && (s_tdata[2:0] > tfb_pkg::MODE_READ);

	// A stalled result stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// An error result never carries a character.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[8] |-> m_tdata[7:0] == 8'd0)
		else $error("error result with nonzero character");

	// A blit finishes in the cycle it is taken.
	a_blit_fast: assert property (@(posedge clk) disable iff (!arst_n)
		blit_acc |=> m_tvalid)
		else $error("blit result not presented");

	// An unknown mode reports an error at once when the output is empty.
	a_bad_mode: assert property (@(posedge clk) disable iff (!arst_n)
		bad_acc && !m_tvalid |=> m_tvalid && m_tdata[8])
		else $error("unknown mode not flagged");

endmodule

bind text_framebuffer_blitter tfb_checker u_tfb_checker (.*);
